[rtl/alb_pkg.sv]
// Shared constants, register codes and types of the APA102 level bar frame encoder.
package alb_pkg;

  localparam int START_BYTES_DEF = 4;
  localparam int END_BYTES_DEF   = 2;
  localparam int NUM_LEDS        = 3;
  localparam int BYTES_PER_LED   = 4;
  localparam int LED_IDX_W       = $clog2(NUM_LEDS);
  localparam int QUEUE_DEPTH     = 2;
  localparam int BRIGHT_W        = 5;

  localparam logic [7:0] HDR_BITS   = 8'hE0;
  localparam logic [7:0] START_BYTE = 8'h00;
  localparam logic [7:0] END_BYTE   = 8'hFF;

  localparam logic [7:0]          THR_FIRST_RST   = 8'd85;
  localparam logic [7:0]          THR_SECOND_RST  = 8'd170;
  localparam logic [7:0]          THR_THIRD_RST   = 8'd255;
  localparam logic [BRIGHT_W-1:0] LIT_BRIGHT_RST  = 5'd3;
  localparam logic [BRIGHT_W-1:0] DARK_BRIGHT_RST = 5'd0;
  localparam logic [7:0]          RED_RST         = 8'd255;
  localparam logic [7:0]          GREEN_RST       = 8'd0;
  localparam logic [7:0]          BLUE_RST        = 8'd0;

  typedef enum logic [2:0] {
    REG_THR_FIRST   = 3'd0,
    REG_THR_SECOND  = 3'd1,
    REG_THR_THIRD   = 3'd2,
    REG_LIT_BRIGHT  = 3'd3,
    REG_DARK_BRIGHT = 3'd4,
    REG_RED         = 3'd5,
    REG_GREEN       = 3'd6,
    REG_BLUE        = 3'd7
  } reg_idx_t;

  // byte position inside one LED record
  typedef enum logic [1:0] {
    LB_HDR   = 2'd0,
    LB_BLUE  = 2'd1,
    LB_GREEN = 2'd2,
    LB_RED   = 2'd3
  } led_byte_t;

  typedef struct packed {
    logic [7:0]          thr_first;
    logic [7:0]          thr_second;
    logic [7:0]          thr_third;
    logic [BRIGHT_W-1:0] lit_bright;
    logic [BRIGHT_W-1:0] dark_bright;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
  } cfg_t;

  typedef logic [NUM_LEDS-1:0] lit_mask_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/alb_front.sv]
// Front end: accepts level samples and turns each into a lit mask for the queue.
module alb_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         level,
  input  alb_pkg::cfg_t      cfg,
  input  alb_pkg::q_stat_t   q_stat,
  output logic               q_push,
  output alb_pkg::lit_mask_t q_push_mask
);

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  // level >= threshold lights the LED; a zero threshold is always lit
  assign q_push_mask = {level >= cfg.thr_third,
                        level >= cfg.thr_second,
                        level >= cfg.thr_first};

endmodule

[rtl/alb_queue.sv]
// Short FIFO of lit masks between the front end and the frame sequencer.
module alb_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  alb_pkg::lit_mask_t push_mask,
  input  logic               pop,
  output alb_pkg::lit_mask_t head,
  output alb_pkg::q_stat_t   stat
);

  localparam int DEPTH = alb_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  alb_pkg::lit_mask_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[rtl/alb_back.sv]
// Back end: walks the head frame into the output register one byte per unstalled cycle.
module alb_back #(
  parameter int START_BYTES = alb_pkg::START_BYTES_DEF,
  parameter int END_BYTES   = alb_pkg::END_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  alb_pkg::cfg_t      cfg,
  input  alb_pkg::q_stat_t   q_stat,
  input  alb_pkg::lit_mask_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         spi_byte,
  output logic               frame_end
);

  localparam int LED_BYTES   = alb_pkg::NUM_LEDS * alb_pkg::BYTES_PER_LED;
  localparam int LED_END     = START_BYTES + LED_BYTES;
  localparam int FRAME_BYTES = LED_END + END_BYTES;
  localparam int PW          = $clog2(FRAME_BYTES);

  logic [PW-1:0]                    pos;
  logic [PW-1:0]                    pos_next;
  logic [PW-1:0]                    led_off;
  logic [alb_pkg::LED_IDX_W-1:0]    led_idx;
  alb_pkg::led_byte_t               sub;
  logic                             lit;
  logic [alb_pkg::BRIGHT_W-1:0]     bright;
  logic [7:0]                       byte_next;
  logic                             last;
  logic                             advance;

  assign advance  = !q_stat.empty && (!out_valid || !out_stall);
  assign last     = (pos == PW'(FRAME_BYTES - 1));
  assign pos_next = last ? '0 : pos + PW'(1);
  assign q_pop    = advance && last;

  always_comb begin
    led_off = pos - PW'(START_BYTES);
    led_idx = led_off[2 +: alb_pkg::LED_IDX_W];
    sub     = alb_pkg::led_byte_t'(led_off[1:0]);
    lit     = 1'b0;
    for (int i = 0; i < alb_pkg::NUM_LEDS; i++) begin
      if (led_idx == alb_pkg::LED_IDX_W'(i)) begin
        lit = q_head[i];
      end
    end
    bright = lit ? cfg.lit_bright : cfg.dark_bright;

    if (pos < PW'(START_BYTES)) begin
      byte_next = alb_pkg::START_BYTE;
    end else if (pos < PW'(LED_END)) begin
      unique case (sub)
        alb_pkg::LB_HDR:   byte_next = alb_pkg::HDR_BITS | {3'b000, bright};
        alb_pkg::LB_BLUE:  byte_next = cfg.blue;
        alb_pkg::LB_GREEN: byte_next = cfg.green;
        alb_pkg::LB_RED:   byte_next = cfg.red;
        default:           byte_next = cfg.red;
      endcase
    end else begin
      byte_next = alb_pkg::END_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        pos       <= pos_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      spi_byte  <= byte_next;
      frame_end <= last;
    end
  end

endmodule

[rtl/apa102_level_bar_frame.sv]
// Top level of the APA102 level bar frame encoder: config registers, front, queue, back.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | sink      | in_valid / in_stall | level[7:0]
//  out     | source    | out_valid/out_stall | spi_byte[7:0], frame_end
//  cfg     | sink      | cfg_valid/cfg_ready | cfg_index[2:0], cfg_data[7:0]
//
// Each level sample yields START_BYTES + 12 + END_BYTES bytes (18 by default),
// one byte per cycle while out is not stalled; the byte sequencer in the
// back end thus sets the pace at which samples are taken at full rate.
// The queue holds two lit masks, so the next sample is taken while a frame
// is still streaming; a taken mask is stored in the queue, then its first byte in the output register.
// Reset is synchronous; it empties the queue and the output register and
// loads the register defaults. No clearing pass is needed.
// A stall on out holds the output byte; the sequencer then waits, and once
// the queue fills, in_stall rises. cfg_ready is always high.
module apa102_level_bar_frame #(
  parameter int START_BYTES = alb_pkg::START_BYTES_DEF,
  parameter int END_BYTES   = alb_pkg::END_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // sample channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] level,
  // byte channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] spi_byte,
  output logic       frame_end,
  // register write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  alb_pkg::cfg_t      cfg;
  alb_pkg::q_stat_t   q_stat;
  alb_pkg::lit_mask_t q_push_mask;
  alb_pkg::lit_mask_t q_head;
  logic               q_push;
  logic               q_pop;

  assign cfg_ready = 1'b1;

  // register file; brightness keeps only its low five bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.thr_first   <= alb_pkg::THR_FIRST_RST;
      cfg.thr_second  <= alb_pkg::THR_SECOND_RST;
      cfg.thr_third   <= alb_pkg::THR_THIRD_RST;
      cfg.lit_bright  <= alb_pkg::LIT_BRIGHT_RST;
      cfg.dark_bright <= alb_pkg::DARK_BRIGHT_RST;
      cfg.red         <= alb_pkg::RED_RST;
      cfg.green       <= alb_pkg::GREEN_RST;
      cfg.blue        <= alb_pkg::BLUE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (alb_pkg::reg_idx_t'(cfg_index))
        alb_pkg::REG_THR_FIRST:   cfg.thr_first   <= cfg_data;
        alb_pkg::REG_THR_SECOND:  cfg.thr_second  <= cfg_data;
        alb_pkg::REG_THR_THIRD:   cfg.thr_third   <= cfg_data;
        alb_pkg::REG_LIT_BRIGHT:  cfg.lit_bright  <= cfg_data[alb_pkg::BRIGHT_W-1:0];
        alb_pkg::REG_DARK_BRIGHT: cfg.dark_bright <= cfg_data[alb_pkg::BRIGHT_W-1:0];
        alb_pkg::REG_RED:         cfg.red         <= cfg_data;
        alb_pkg::REG_GREEN:       cfg.green       <= cfg_data;
        alb_pkg::REG_BLUE:        cfg.blue        <= cfg_data;
        default:                  cfg.blue        <= cfg.blue;
      endcase
    end
  end

  // thresholds are compared at accept; only the mask is queued
  alb_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .level       (level),
    .cfg         (cfg),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_push_mask (q_push_mask)
  );

  alb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_mask (q_push_mask),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // the head entry stays in the queue until its last byte is sent
  alb_back #(
    .START_BYTES (START_BYTES),
    .END_BYTES   (END_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .spi_byte  (spi_byte),
    .frame_end (frame_end)
  );

endmodule

[rtl/alb_checker.sv]
// Port-level checker of the APA102 level bar frame encoder, bound to the top level.
module alb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] spi_byte,
  input logic       frame_end
);

  // stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(spi_byte) && $stable(frame_end))
    else $error("output transaction changed while stalled");

  // the flagged byte is always an end byte
  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> spi_byte == alb_pkg::END_BYTE)
    else $error("frame_end on a byte that is not an end byte");

  a_rst_out: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  a_rst_in: assert property (@(posedge clk) $past(rst) |-> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind apa102_level_bar_frame alb_checker u_alb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .spi_byte  (spi_byte),
  .frame_end (frame_end)
);
